FILE: rtl/tss_pkg.sv
package tss_pkg;

    // Protocol sizes.
    localparam int BLOCK_BYTES      = 512;
    localparam int MAX_PACKET_BYTES = 1024;
    localparam int HDR_BYTES        = 4;
    localparam int WRITE_LEN_MAX    = 1023;

    // Received packet opcodes.
    localparam logic [15:0] OP_RRQ  = 16'd1;
    localparam logic [15:0] OP_WRQ  = 16'd2;
    localparam logic [15:0] OP_DATA = 16'd3;
    localparam logic [15:0] OP_ACK  = 16'd4;

    // Item kinds.
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Packet kinds to send.
    localparam logic [1:0] SK_NONE  = 2'd0;
    localparam logic [1:0] SK_ACK   = 2'd1;
    localparam logic [1:0] SK_DATA  = 2'd2;
    localparam logic [1:0] SK_ERROR = 2'd3;

    // TFTP error codes.
    localparam logic [2:0] ERR_UNDEF     = 3'd0;
    localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
    localparam logic [2:0] ERR_ACCESS    = 3'd2;

    // Configuration register indexes.
    localparam logic CFG_RETRY_LIMIT   = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    // Command classes handed from the front end to the back end.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_TICK  = 3'd1;
    localparam logic [2:0] CMD_ERROR = 3'd2;
    localparam logic [2:0] CMD_RRQ   = 3'd3;
    localparam logic [2:0] CMD_WRQ   = 3'd4;
    localparam logic [2:0] CMD_DATA  = 3'd5;
    localparam logic [2:0] CMD_ACK   = 3'd6;

    typedef struct packed {
        logic        kind;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [10:0] packet_len;
        logic        mode_ok;
        logic        file_ok;
        logic [9:0]  chunk_len;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_block;
        logic [9:0]  send_data_len;
        logic [2:0]  error_code;
        logic        write_valid;
        logic [9:0]  write_len;
        logic        close_write;
        logic        close_read;
        logic        transfer_failed;
    } t_out_item;

    // Classified request as it sits in the queue.
    typedef struct packed {
        logic [2:0]  cls;
        logic [15:0] blk;
        logic [9:0]  chunk;
        logic        chunk_short;
        logic [2:0]  err;
        logic [9:0]  wr_len;
        logic        wr_close;
    } t_cmd;

endpackage

FILE: rtl/tss_front.sv
module tss_front (
    input  tss_pkg::t_in_item i_item,
    output tss_pkg::t_cmd     o_cmd
);
    import tss_pkg::*;

    logic [10:0] plen_eff;
    logic [10:0] pay;
    logic [9:0]  chunk_clamped;

    // Stateless arithmetic on the packet fields.
    always_comb begin
        plen_eff = (i_item.packet_len > 11'(MAX_PACKET_BYTES)) ?
                   11'(MAX_PACKET_BYTES) : i_item.packet_len;
        pay = plen_eff - 11'(HDR_BYTES);
        chunk_clamped = (i_item.chunk_len > 10'(BLOCK_BYTES)) ?
                        10'(BLOCK_BYTES) : i_item.chunk_len;
    end

    // Classify the request; errors that depend on no state are settled here.
    always_comb begin
        o_cmd             = '0;
        o_cmd.blk         = i_item.block_number;
        o_cmd.chunk       = chunk_clamped;
        o_cmd.chunk_short = (chunk_clamped < 10'(BLOCK_BYTES));
        o_cmd.wr_len      = (pay > 11'(WRITE_LEN_MAX)) ? 10'(WRITE_LEN_MAX) : pay[9:0];
        o_cmd.wr_close    = (pay != 11'(BLOCK_BYTES));
        o_cmd.cls         = CMD_NONE;
        o_cmd.err         = ERR_UNDEF;
        if (i_item.kind == KIND_TICK) begin
            o_cmd.cls = CMD_TICK;
        end else begin
            case (i_item.opcode)
                OP_RRQ: begin
                    if (!i_item.mode_ok) begin
                        o_cmd.cls = CMD_ERROR;
                        o_cmd.err = ERR_UNDEF;
                    end else if (!i_item.file_ok) begin
                        o_cmd.cls = CMD_ERROR;
                        o_cmd.err = ERR_NOT_FOUND;
                    end else begin
                        o_cmd.cls = CMD_RRQ;
                    end
                end
                OP_WRQ: begin
                    if (!i_item.mode_ok) begin
                        o_cmd.cls = CMD_ERROR;
                        o_cmd.err = ERR_NOT_FOUND;
                    end else if (!i_item.file_ok) begin
                        o_cmd.cls = CMD_ERROR;
                        o_cmd.err = ERR_ACCESS;
                    end else begin
                        o_cmd.cls = CMD_WRQ;
                    end
                end
                OP_DATA: begin
                    if (i_item.packet_len < 11'(HDR_BYTES)) begin
                        o_cmd.cls = CMD_ERROR;
                        o_cmd.err = ERR_UNDEF;
                    end else begin
                        o_cmd.cls = CMD_DATA;
                    end
                end
                OP_ACK: begin
                    o_cmd.cls = CMD_ACK;
                end
                default: begin
                    o_cmd.cls = CMD_NONE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/tss_fifo.sv
module tss_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tss_pkg::t_cmd i_data,
    input  logic          i_pop,
    output tss_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);
    import tss_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/tss_back.sv
module tss_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  tss_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_avail,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tss_pkg::t_out_item o_out_item
);
    import tss_pkg::*;

    logic [3:0]  r_retry_limit;
    logic [7:0]  r_timeout_ticks;
    logic [15:0] r_write_block,  n_write_block;
    logic [15:0] r_read_block,   n_read_block;
    logic [9:0]  r_read_chunk,   n_read_chunk;
    logic [3:0]  r_retry_count,  n_retry_count;
    logic        r_file_end,     n_file_end;
    logic [7:0]  r_timer_rem,    n_timer_rem;
    logic        r_timer_armed,  n_timer_armed;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_res;
    logic [15:0] write_next;
    logic [15:0] read_next;

    // Take the next request whenever the output register is free or drains.
    assign o_cmd_pop   = i_cmd_avail && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign write_next  = r_write_block + 16'd1;
    assign read_next   = r_read_block + 16'd1;

    // Transfer sequencing against the current state.
    always_comb begin
        n_write_block = r_write_block;
        n_read_block  = r_read_block;
        n_read_chunk  = r_read_chunk;
        n_retry_count = r_retry_count;
        n_file_end    = r_file_end;
        n_timer_rem   = r_timer_rem;
        n_timer_armed = r_timer_armed;
        n_res         = '0;
        case (i_cmd.cls)
            CMD_TICK: begin
                if (r_timer_armed) begin
                    if (r_timer_rem <= 8'd1) begin
                        if (r_retry_count >= r_retry_limit) begin
                            n_retry_count         = 4'd0;
                            n_timer_armed         = 1'b0;
                            n_timer_rem           = 8'd0;
                            n_res.transfer_failed = 1'b1;
                        end else begin
                            n_retry_count       = r_retry_count + 4'd1;
                            n_res.send_kind     = SK_DATA;
                            n_res.send_block    = r_read_block;
                            n_res.send_data_len = r_read_chunk;
                            n_timer_armed       = 1'b1;
                            n_timer_rem         = r_timeout_ticks;
                        end
                    end else begin
                        n_timer_rem = r_timer_rem - 8'd1;
                    end
                end
            end
            CMD_ERROR: begin
                n_res.send_kind  = SK_ERROR;
                n_res.error_code = i_cmd.err;
            end
            CMD_RRQ: begin
                n_read_block        = 16'd1;
                n_retry_count       = 4'd0;
                n_file_end          = i_cmd.chunk_short;
                n_read_chunk        = i_cmd.chunk;
                n_res.send_kind     = SK_DATA;
                n_res.send_block    = 16'd1;
                n_res.send_data_len = i_cmd.chunk;
                n_res.close_read    = i_cmd.chunk_short;
                n_timer_armed       = 1'b1;
                n_timer_rem         = r_timeout_ticks;
            end
            CMD_WRQ: begin
                n_write_block    = 16'd0;
                n_res.send_kind  = SK_ACK;
                n_res.send_block = 16'd0;
            end
            CMD_DATA: begin
                if (i_cmd.blk == write_next) begin
                    n_write_block     = i_cmd.wr_close ? 16'd0 : i_cmd.blk;
                    n_res.send_kind   = SK_ACK;
                    n_res.send_block  = i_cmd.blk;
                    n_res.write_valid = 1'b1;
                    n_res.write_len   = i_cmd.wr_len;
                    n_res.close_write = i_cmd.wr_close;
                end
            end
            CMD_ACK: begin
                if (r_file_end) begin
                    n_timer_armed    = 1'b0;
                    n_timer_rem      = 8'd0;
                    n_res.send_kind  = SK_ACK;
                    n_res.send_block = read_next;
                end else begin
                    n_retry_count = 4'd0;
                    if (i_cmd.blk == r_read_block) begin
                        n_read_block        = read_next;
                        n_read_chunk        = i_cmd.chunk;
                        n_res.send_kind     = SK_DATA;
                        n_res.send_block    = read_next;
                        n_res.send_data_len = i_cmd.chunk;
                        n_res.close_read    = i_cmd.chunk_short;
                        if (i_cmd.chunk_short) begin
                            n_file_end = 1'b1;
                        end
                        n_timer_armed = 1'b1;
                        n_timer_rem   = r_timeout_ticks;
                    end
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit   <= 4'd5;
            r_timeout_ticks <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RETRY_LIMIT:   r_retry_limit   <= i_cfg_data[3:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default:           r_retry_limit   <= r_retry_limit;
            endcase
        end
    end

    // Transfer state advances only when a request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_block <= 16'd0;
            r_read_block  <= 16'd0;
            r_read_chunk  <= 10'd0;
            r_retry_count <= 4'd0;
            r_file_end    <= 1'b0;
            r_timer_rem   <= 8'd0;
            r_timer_armed <= 1'b0;
        end else if (o_cmd_pop) begin
            r_write_block <= n_write_block;
            r_read_block  <= n_read_block;
            r_read_chunk  <= n_read_chunk;
            r_retry_count <= n_retry_count;
            r_file_end    <= n_file_end;
            r_timer_rem   <= n_timer_rem;
            r_timer_armed <= n_timer_armed;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out_item <= n_res;
        end
    end

    // A stopped timer never keeps a count.
    a_timer_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_timer_armed |-> r_timer_rem == 8'd0)
        else $error("timer count left while stopped");

    // Exhausted retries stop the timer and raise failure.
    a_fail_stops_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.cls == CMD_TICK && r_timer_armed && r_timer_rem <= 8'd1
         && r_retry_count >= r_retry_limit)
        |=> !r_timer_armed && r_out_item.transfer_failed && r_retry_count == 4'd0)
        else $error("retry exhaustion not handled");

    // An accepted read request starts block one with the timer running.
    a_rrq_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.cls == CMD_RRQ)
        |=> r_read_block == 16'd1 && r_timer_armed && r_out_item.send_kind == SK_DATA)
        else $error("read request did not start transfer");

    // A new result is never loaded over one that is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd_pop)
        else $error("held result overwritten");

endmodule

FILE: rtl/tftp_server_block_sequencer_top.sv
// TFTP server block sequencer.
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one request per
// accepted handshake: a decoded received packet or a single timer tick.
// Output channel (o_out_valid / i_out_ready / o_out_item) returns exactly one
// result per request, in order: the packet to send plus write, close and
// failure strobes.
// The configuration port writes retry_limit (index 0) or timeout_ticks
// (index 1) on any clock with i_cfg_we high; write only while the block is idle.
// A front end classifies each request, a two-entry queue holds it, and a back
// end applies it to the transfer state and loads the output register.
// An accepted request is written into the queue, and the back end takes it from
// there into the output register, which presents the result; one request per
// cycle is sustained while the receiver does not stall, since each request is a
// single compare-and-update of the transfer registers in the back end.
// Reset clears the transfer state, stops the timer, empties the queue and
// restores retry_limit to 5 and timeout_ticks to 2.
// When the receiver stalls, the result holds in the output register, the queue
// absorbs up to two more requests, and then o_in_ready drops until the
// receiver takes the held result.
module tftp_server_block_sequencer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tss_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tss_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    import tss_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;

    // Requests enter whenever the queue has room.
    assign o_in_ready = !queue_full;
    assign push       = i_in_valid && !queue_full;

    tss_front u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    tss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (queue_cmd),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    tss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (queue_cmd),
        .i_cmd_avail (!queue_empty),
        .o_cmd_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    // One row of the directed table: a request and, where it is obvious,
    // the result typed in by hand.
    typedef struct packed {
        t_in_item  req;
        logic      typed;
        t_out_item want;
    } t_row;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_item;
    logic       cfg_we;
    logic       cfg_idx;
    logic [7:0] cfg_data;

    // Configuration as the sequencer should currently hold it.
    logic [3:0] cfg_retry_limit;
    logic [7:0] cfg_timeout;

    // Transfer state of the sequencer as predicted here.
    logic [15:0] p_wr_block;
    logic [15:0] p_rd_block;
    logic [9:0]  p_rd_chunk;
    logic [3:0]  p_retry;
    logic        p_end_sent;
    logic [7:0]  p_remaining;
    logic        p_armed;

    t_out_item expected_q[$];
    t_row      dir_rows[$];

    logic quiet;
    int   n_mismatch;
    int   n_requests;
    int   n_results;
    int   n_resends;
    int   n_failures;
    int   n_closes;

    tftp_server_block_sequencer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case the sequencer hangs.
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        n_mismatch++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic t_in_item mk(input logic kind, input logic [15:0] op,
                                    input logic [15:0] blk, input logic [10:0] plen,
                                    input logic mode, input logic file,
                                    input logic [9:0] chunk);
        t_in_item it;
        it.kind         = kind;
        it.opcode       = op;
        it.block_number = blk;
        it.packet_len   = plen;
        it.mode_ok      = mode;
        it.file_ok      = file;
        it.chunk_len    = chunk;
        return it;
    endfunction

    function automatic t_out_item simple_out(input logic [1:0] k, input logic [2:0] code);
        t_out_item o;
        o            = '0;
        o.send_kind  = k;
        o.error_code = code;
        return o;
    endfunction

    // Restart the retransmit countdown.
    function automatic void arm_retransmit();
        p_armed     = 1'b1;
        p_remaining = cfg_timeout;
    endfunction

    // Apply one request to the predicted transfer state and return the result.
    function automatic t_out_item tftp_step(input t_in_item it);
        t_out_item o;
        logic [9:0] chunk;
        int eff;
        int pay;
        o     = '0;
        chunk = (it.chunk_len > BLOCK_BYTES) ? 10'(BLOCK_BYTES) : it.chunk_len;
        if (it.kind == KIND_TICK) begin
            if (p_armed) begin
                if (p_remaining <= 8'd1) begin
                    if (p_retry >= cfg_retry_limit) begin
                        // Retries used up: give up on this transfer.
                        p_retry           = '0;
                        p_armed           = 1'b0;
                        p_remaining       = '0;
                        o.transfer_failed = 1'b1;
                        n_failures++;
                    end else begin
                        p_retry         = p_retry + 4'd1;
                        o.send_kind     = SK_DATA;
                        o.send_block    = p_rd_block;
                        o.send_data_len = p_rd_chunk;
                        arm_retransmit();
                        n_resends++;
                    end
                end else begin
                    p_remaining = p_remaining - 8'd1;
                end
            end
        end else begin
            case (it.opcode)
                OP_RRQ: begin
                    if (!it.mode_ok) begin
                        o = simple_out(SK_ERROR, ERR_UNDEF);
                    end else if (!it.file_ok) begin
                        o = simple_out(SK_ERROR, ERR_NOT_FOUND);
                    end else begin
                        p_rd_block      = 16'd1;
                        p_retry         = '0;
                        p_end_sent      = 1'b0;
                        p_rd_chunk      = chunk;
                        o.send_kind     = SK_DATA;
                        o.send_block    = p_rd_block;
                        o.send_data_len = chunk;
                        if (chunk < BLOCK_BYTES) begin
                            o.close_read = 1'b1;
                            p_end_sent   = 1'b1;
                            n_closes++;
                        end
                        arm_retransmit();
                    end
                end
                OP_WRQ: begin
                    if (!it.mode_ok) begin
                        o = simple_out(SK_ERROR, ERR_NOT_FOUND);
                    end else if (!it.file_ok) begin
                        o = simple_out(SK_ERROR, ERR_ACCESS);
                    end else begin
                        p_wr_block = '0;
                        o          = simple_out(SK_ACK, ERR_UNDEF);
                    end
                end
                OP_DATA: begin
                    if (it.packet_len < HDR_BYTES) begin
                        o = simple_out(SK_ERROR, ERR_UNDEF);
                    end else if (it.block_number == 16'(p_wr_block + 16'd1)) begin
                        eff = (it.packet_len > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES
                                                                 : int'(it.packet_len);
                        pay = eff - HDR_BYTES;
                        p_wr_block    = it.block_number;
                        o.send_kind   = SK_ACK;
                        o.send_block  = it.block_number;
                        o.write_valid = 1'b1;
                        o.write_len   = 10'((pay > WRITE_LEN_MAX) ? WRITE_LEN_MAX : pay);
                        // Anything but a full block ends the upload.
                        if (pay != BLOCK_BYTES) begin
                            o.close_write = 1'b1;
                            p_wr_block    = '0;
                            n_closes++;
                        end
                    end
                end
                OP_ACK: begin
                    if (p_end_sent) begin
                        p_armed      = 1'b0;
                        p_remaining  = '0;
                        o.send_kind  = SK_ACK;
                        o.send_block = p_rd_block + 16'd1;
                    end else begin
                        p_retry = '0;
                        if (it.block_number == p_rd_block) begin
                            p_rd_block      = p_rd_block + 16'd1;
                            p_rd_chunk      = chunk;
                            o.send_kind     = SK_DATA;
                            o.send_block    = p_rd_block;
                            o.send_data_len = chunk;
                            if (chunk < BLOCK_BYTES) begin
                                o.close_read = 1'b1;
                                p_end_sent   = 1'b1;
                                n_closes++;
                            end
                            arm_retransmit();
                        end
                    end
                end
                default: ;
            endcase
        end
        return o;
    endfunction

    // Drive one request at the falling edge, hold it until accepted, and
    // record what should come back.
    int calm_in;
    task automatic send_request(input t_in_item it, input logic typed, input t_out_item typed_out);
        t_out_item want;
        if (!quiet) begin
            if (calm_in > 0) begin
                calm_in--;
            end else if ($urandom_range(0, 19) == 0) begin
                calm_in = $urandom_range(15, 60);
            end else if ($urandom_range(0, 4) == 0) begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        want = tftp_step(it);
        if (typed) begin
            want = typed_out;
        end
        expected_q.push_back(want);
        n_requests++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every result is back.
    task automatic drain();
        in_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_RETRY_LIMIT) begin
            cfg_retry_limit = val[3:0];
        end else begin
            cfg_timeout = val;
        end
    endtask

    // Random request, mostly following a read or an upload in progress.
    function automatic t_in_item pick_request();
        t_in_item    it;
        logic [63:0] r;
        int unsigned sel;
        r   = {$urandom, $urandom};
        it  = r[55:0];
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            // Noise: every field random, opcode often near the real ones.
            if ($urandom_range(0, 1) == 0) begin
                it.opcode = 16'($urandom_range(0, 6));
            end
        end else if (sel < 36) begin
            it.kind = KIND_TICK;
        end else if (sel < 68) begin
            it.kind      = KIND_PACKET;
            it.chunk_len = ($urandom_range(0, 9) < 7) ? 10'(BLOCK_BYTES) : 10'($urandom);
            if (!p_armed && $urandom_range(0, 9) != 0) begin
                it.opcode  = OP_RRQ;
                it.mode_ok = ($urandom_range(0, 19) != 0);
                it.file_ok = ($urandom_range(0, 19) != 0);
            end else begin
                it.opcode = OP_ACK;
                if ($urandom_range(0, 4) != 0) begin
                    it.block_number = p_rd_block;
                end else if ($urandom_range(0, 1) == 0) begin
                    it.block_number = p_rd_block - 16'd1;
                end
            end
        end else begin
            it.kind = KIND_PACKET;
            if ((p_wr_block == 16'd0 && $urandom_range(0, 2) == 0)
                    || $urandom_range(0, 19) == 0) begin
                it.opcode  = OP_WRQ;
                it.mode_ok = ($urandom_range(0, 9) != 0);
                it.file_ok = ($urandom_range(0, 9) != 0);
            end else begin
                it.opcode = OP_DATA;
                if ($urandom_range(0, 6) != 0) begin
                    it.block_number = p_wr_block + 16'd1;
                end
                if ($urandom_range(0, 4) != 0) begin
                    it.packet_len = 11'(BLOCK_BYTES + HDR_BYTES);
                end
            end
        end
        return it;
    endfunction

    task automatic run_phase(input logic do_write, input logic [7:0] retry,
                             input logic [7:0] timeout, input int count);
        int i;
        int k;
        if (do_write) begin
            drain();
            write_reg(CFG_RETRY_LIMIT, retry);
            write_reg(CFG_TIMEOUT_TICKS, timeout);
        end
        i = 0;
        while (i < count) begin
            if ($urandom_range(0, 49) == 0) begin
                // A run of ticks with no answer, at times long enough to use up retries.
                for (k = $urandom_range(8, 40); k > 0; k--) begin
                    send_request(mk(KIND_TICK, 16'($urandom), 16'($urandom), 11'($urandom),
                                    1'($urandom), 1'($urandom), 10'($urandom)),
                                 1'b0, '0);
                    i++;
                end
            end else begin
                send_request(pick_request(), 1'b0, '0);
                i++;
            end
        end
    endtask

    // Receiver side: random stall bursts with calm stretches in between.
    initial begin
        out_ready = 1'b1;
        forever begin
            @(negedge clk);
            if (!quiet) begin
                if ($urandom_range(0, 29) == 0) begin
                    repeat ($urandom_range(20, 80)) @(negedge clk);
                end else if ($urandom_range(0, 5) == 0) begin
                    out_ready = 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge clk);
                    out_ready = 1'b1;
                end
            end
        end
    end

    // Compare each returned result with the oldest expectation.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = expected_q.pop_front();
                check_field("send_kind", int'(out_item.send_kind), int'(want.send_kind));
                check_field("send_block", int'(out_item.send_block), int'(want.send_block));
                check_field("send_data_len", int'(out_item.send_data_len),
                            int'(want.send_data_len));
                check_field("error_code", int'(out_item.error_code), int'(want.error_code));
                check_field("write_valid", int'(out_item.write_valid),
                            int'(want.write_valid));
                check_field("write_len", int'(out_item.write_len), int'(want.write_len));
                check_field("close_write", int'(out_item.close_write),
                            int'(want.close_write));
                check_field("close_read", int'(out_item.close_read), int'(want.close_read));
                check_field("transfer_failed", int'(out_item.transfer_failed),
                            int'(want.transfer_failed));
            end
        end
    end

    // Main sequence.
    initial begin
        int   i;
        t_row row;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_item         = '0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_RETRY_LIMIT;
        cfg_data        = '0;
        quiet           = 1'b0;
        calm_in         = 0;
        n_mismatch      = 0;
        n_requests      = 0;
        n_results       = 0;
        n_resends       = 0;
        n_failures      = 0;
        n_closes        = 0;
        cfg_retry_limit = 4'd5;
        cfg_timeout     = 8'd2;
        p_wr_block      = '0;
        p_rd_block      = '0;
        p_rd_chunk      = '0;
        p_retry         = '0;
        p_end_sent      = 1'b0;
        p_remaining     = '0;
        p_armed         = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: ignored items, every error, uploads, a short download.
        dir_rows.push_back('{mk(KIND_TICK, 16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1, 1'b1, 10'h3FF),
                             1'b1, simple_out(SK_NONE, ERR_UNDEF)});
        dir_rows.push_back('{mk(KIND_PACKET, 16'd0, 16'd0, 11'd0, 1'b0, 1'b0, 10'd0),
                             1'b1, simple_out(SK_NONE, ERR_UNDEF)});
        dir_rows.push_back('{mk(KIND_PACKET, 16'd5, 16'd1, 11'd20, 1'b1, 1'b1, 10'd512),
                             1'b1, simple_out(SK_NONE, ERR_UNDEF)});
        dir_rows.push_back('{mk(KIND_PACKET, 16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1, 1'b1,
                                10'h3FF),
                             1'b1, simple_out(SK_NONE, ERR_UNDEF)});
        dir_rows.push_back('{mk(KIND_PACKET, OP_RRQ, 16'd0, 11'd9, 1'b0, 1'b1, 10'd512),
                             1'b1, simple_out(SK_ERROR, ERR_UNDEF)});
        dir_rows.push_back('{mk(KIND_PACKET, OP_RRQ, 16'd0, 11'd9, 1'b1, 1'b0, 10'd512),
                             1'b1, simple_out(SK_ERROR, ERR_NOT_FOUND)});
        dir_rows.push_back('{mk(KIND_PACKET, OP_WRQ, 16'd0, 11'd9, 1'b0, 1'b1, 10'd0),
                             1'b1, simple_out(SK_ERROR, ERR_NOT_FOUND)});
        dir_rows.push_back('{mk(KIND_PACKET, OP_WRQ, 16'd0, 11'd9, 1'b1, 1'b0, 10'd0),
                             1'b1, simple_out(SK_ERROR, ERR_ACCESS)});
        dir_rows.push_back('{mk(KIND_PACKET, OP_DATA, 16'd1, 11'd0, 1'b1, 1'b1, 10'd0),
                             1'b1, simple_out(SK_ERROR, ERR_UNDEF)});
        dir_rows.push_back('{mk(KIND_PACKET, OP_DATA, 16'd1, 11'd3, 1'b1, 1'b1, 10'd0),
                             1'b1, simple_out(SK_ERROR, ERR_UNDEF)});
        // ACK with no read transfer open, then a stray ACK.
        dir_rows.push_back('{mk(KIND_PACKET, OP_ACK, 16'd0, 11'd4, 1'b0, 1'b0, 10'd512),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_PACKET, OP_ACK, 16'hFFFF, 11'd4, 1'b0, 1'b0, 10'd5),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_PACKET, OP_WRQ, 16'd0, 11'd9, 1'b1, 1'b1, 10'd0),
                             1'b1, simple_out(SK_ACK, ERR_UNDEF)});
        dir_rows.push_back('{mk(KIND_PACKET, OP_DATA, 16'd1, 11'd516, 1'b1, 1'b1, 10'd0),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_PACKET, OP_DATA, 16'd9, 11'd516, 1'b1, 1'b1, 10'd0),
                             1'b0, '0});
        // Oversized packet, then an empty final block.
        dir_rows.push_back('{mk(KIND_PACKET, OP_DATA, 16'd2, 11'h7FF, 1'b1, 1'b1, 10'd0),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_PACKET, OP_DATA, 16'd1, 11'd4, 1'b1, 1'b1, 10'd0),
                             1'b0, '0});
        // Oversized chunk, a timeout resend, then a download ending on an empty block.
        dir_rows.push_back('{mk(KIND_PACKET, OP_RRQ, 16'd0, 11'd9, 1'b1, 1'b1, 10'h3FF),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_TICK, 16'd0, 16'd0, 11'd0, 1'b0, 1'b0, 10'd0),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_TICK, 16'd0, 16'd0, 11'd0, 1'b0, 1'b0, 10'd0),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_PACKET, OP_ACK, 16'd1, 11'd4, 1'b0, 1'b0, 10'd512),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_PACKET, OP_ACK, 16'd2, 11'd4, 1'b0, 1'b0, 10'd0),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_TICK, 16'd0, 16'd0, 11'd0, 1'b0, 1'b0, 10'd0),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_TICK, 16'd0, 16'd0, 11'd0, 1'b0, 1'b0, 10'd0),
                             1'b0, '0});
        // ACK after the end of file stops the timer.
        dir_rows.push_back('{mk(KIND_PACKET, OP_ACK, 16'd3, 11'd4, 1'b0, 1'b0, 10'd0),
                             1'b0, '0});
        dir_rows.push_back('{mk(KIND_TICK, 16'd0, 16'd0, 11'd0, 1'b0, 1'b0, 10'd0),
                             1'b0, '0});
        for (i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            send_request(row.req, row.typed, row.want);
        end

        // Random phases across several register settings, extremes included.
        run_phase(1'b0, 8'd5, 8'd2, 190);
        run_phase(1'b1, 8'd0, 8'd1, 190);
        run_phase(1'b1, 8'd15, 8'd255, 190);
        run_phase(1'b1, 8'd2, 8'd0, 190);
        run_phase(1'b1, 8'd15, 8'd1, 190);
        quiet = 1'b1;
        run_phase(1'b1, 8'd3, 8'd4, 190);

        // Wait for the last results, then a few more cycles for strays.
        in_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d requests, %0d results over every error path and six settings",
                 n_requests, n_results);
        $display("tb: %0d resends, %0d abandoned transfers, %0d file closes, %0d mismatches",
                 n_resends, n_failures, n_closes, n_mismatch);
        if (n_mismatch == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tss_pkg.sv
rtl/tss_front.sv
rtl/tss_fifo.sv
rtl/tss_back.sv
rtl/tftp_server_block_sequencer_top.sv
verif/tb.sv
